// ===== design/cwo_pkg.sv =====
// Package for the crop window offset calculator.
// Holds shared widths, mode, error and register codes, and the fixed view tables.
// No dependencies.
`timescale 1ns / 1ps

package cwo_pkg;

  localparam int OUT_W       = 13;
  localparam int ERR_W       = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int RATIO_W     = 17;
  localparam int MODE_W      = 3;
  localparam int SEG_W       = 5;
  localparam int OSIZE_W     = 12;
  localparam int VIEW_W      = 8;
  localparam int RAND_W      = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int FV_EDGE2    = 2800;
  localparam int TEN_VIEWS   = 10;
  localparam int EIGHTEEN_VIEWS = 18;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

  typedef enum logic [MODE_W-1:0] {
    MODE_RANDOM   = 3'd0,
    MODE_TEN      = 3'd1,
    MODE_CENTER   = 3'd2,
    MODE_EIGHTEEN = 3'd3,
    MODE_MULTI    = 3'd4,
    MODE_FULL     = 3'd5
  } mode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK   = 2'd0,
    ERR_MODE = 2'd1,
    ERR_VIEW = 2'd2,
    ERR_BIG  = 2'd3
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATIO  = 3'd0,
    REG_MODE   = 3'd1,
    REG_ACROSS = 3'd2,
    REG_DOWN   = 3'd3,
    REG_OSIZE  = 3'd4
  } reg_idx_t;

  // Multiples of the half span for each fixed view; the ten-view table is the head of this one.
  localparam logic [1:0] VIEW_X [EIGHTEEN_VIEWS] = '{
    2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0,
    2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0
  };
  localparam logic [1:0] VIEW_Y [EIGHTEEN_VIEWS] = '{
    2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd0, 2'd1, 2'd2, 2'd1,
    2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd1
  };

  function automatic logic [1:0] view_x(input logic [4:0] v);
    logic [1:0] r;
    r = 2'd0;
    if (v < 5'(EIGHTEEN_VIEWS)) r = VIEW_X[v];
    return r;
  endfunction

  function automatic logic [1:0] view_y(input logic [4:0] v);
    logic [1:0] r;
    r = 2'd0;
    if (v < 5'(EIGHTEEN_VIEWS)) r = VIEW_Y[v];
    return r;
  endfunction

endpackage

// ===== design/cwo_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; all stages advance together on the shared enable.
`timescale 1ns / 1ps

module cwo_div #(
  parameter int NW = 8,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic [NW-1:0] q_r [NW];
  logic [DW-1:0] r_r [NW];
  logic [DW-1:0] d_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] q_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign q_in = num;
      assign r_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign q_in = q_r[k-1];
      assign r_in = r_r[k-1];
      assign d_in = d_r[k-1];
    end

    assign trial = {r_in, q_in[NW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= {q_in[NW-2:0], ge};
        r_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        d_r[k] <= d_in;
      end
    end
  end

  assign quo = q_r[NW-1];
  assign rem = r_r[NW-1];

endmodule

// ===== design/cwo_dly.sv =====
// Enabled delay line that keeps side data aligned with the divider stages.
// Standalone; no reset on the data it carries.
`timescale 1ns / 1ps

module cwo_dly #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  if (DEPTH == 0) begin : g_none
    assign q = d;
  end else begin : g_line
    logic [W-1:0] sr_r [DEPTH];
    always_ff @(posedge clk) begin
      if (en) begin
        sr_r[0] <= d;
        for (int i = 1; i < DEPTH; i++) sr_r[i] <= sr_r[i-1];
      end
    end
    assign q = sr_r[DEPTH-1];
  end

endmodule

// ===== design/crop_window_offset_calc_core.sv =====
// Top level of the square crop window calculator.
// Uses cwo_pkg, cwo_div and cwo_dly.
//
// Usage: each beat on the in_ channel carries one crop request (image width and
// height, view index, two random words). Each request gives exactly one beat on
// the out_ channel with the x and y offsets, the crop side and an error code.
// Configuration registers are written through cfg_wr_en, cfg_index and cfg_wdata
// while no request is in flight; writes to indexes past the last register are
// ignored.
// Throughput is one beat per cycle while out_tready does not stall the output. The
// pipeline depth is the longer of the random-word dividers and the chained grid
// dividers: view split, row, then the grid offset.
// Synchronous active-low reset clears all valid bits and loads the register
// defaults. When the receiver holds out_tready low with a beat waiting, the whole
// pipeline freezes and in_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module crop_window_offset_calc_core #(
  parameter int COORD_BITS = 13
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // image_width, image_height, view_index, random_y, random_x
  input  logic [((2*COORD_BITS+70)+7)/8*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // x_offset, y_offset, crop_side, error_code
  output logic [cwo_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic cfg_wr_en,
  input  logic [cwo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwo_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CB   = COORD_BITS;
  localparam int OW   = cwo_pkg::OUT_W;
  localparam int SW   = cwo_pkg::SEG_W;
  localparam int GNW  = CB + 6;
  localparam int FNW  = CB + 12;
  localparam int RNW  = cwo_pkg::RAND_W;
  localparam int L    = (RNW > CB + 22) ? RNW : CB + 22;
  localparam int CW   = 7*CB + cwo_pkg::VIEW_W + 2*SW;

  // Configuration registers.
  logic [cwo_pkg::RATIO_W-1:0] cfg_ratio_r;
  logic [cwo_pkg::MODE_W-1:0]  cfg_mode_r;
  logic [SW-1:0]               cfg_across_r;
  logic [SW-1:0]               cfg_down_r;
  logic [cwo_pkg::OSIZE_W-1:0] cfg_osize_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ratio_r  <= cwo_pkg::RATIO_ONE;
      cfg_mode_r   <= cwo_pkg::MODE_RANDOM;
      cfg_across_r <= SW'(1);
      cfg_down_r   <= SW'(1);
      cfg_osize_r  <= 12'd224;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cwo_pkg::REG_RATIO:  cfg_ratio_r  <= cfg_wdata;
        cwo_pkg::REG_MODE:   cfg_mode_r   <= cfg_wdata[cwo_pkg::MODE_W-1:0];
        cwo_pkg::REG_ACROSS: cfg_across_r <= cfg_wdata[SW-1:0];
        cwo_pkg::REG_DOWN:   cfg_down_r   <= cfg_wdata[SW-1:0];
        cwo_pkg::REG_OSIZE:  cfg_osize_r  <= cfg_wdata[cwo_pkg::OSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic          en;
  logic [L+1:0]  vld_r;
  logic          out_tvalid_r;
  logic [cwo_pkg::OUT_TDATA_W-1:0] out_data_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vld_r        <= {vld_r[L:0], in_tvalid};
      out_tvalid_r <= vld_r[L+1];
    end
  end

  // Stage 1: crop side.
  logic [CB-1:0] in_w, in_h, in_mn;
  logic [cwo_pkg::VIEW_W-1:0] in_view;
  logic [RNW-1:0] in_ry, in_rx;
  logic [cwo_pkg::RATIO_W-1:0] ratio;
  logic [CB+16:0] side_prod;

  assign in_w    = in_tdata[CB-1:0];
  assign in_h    = in_tdata[2*CB-1:CB];
  assign in_view = in_tdata[2*CB+7:2*CB];
  assign in_ry   = in_tdata[2*CB+38:2*CB+8];
  assign in_rx   = in_tdata[2*CB+69:2*CB+39];
  assign in_mn   = (in_w < in_h) ? in_w : in_h;
  assign ratio   = (cfg_ratio_r > cwo_pkg::RATIO_ONE) ? cwo_pkg::RATIO_ONE : cfg_ratio_r;
  assign side_prod = (CB+17)'(in_mn) * (CB+17)'(ratio);

  logic [CB-1:0] s1_w_r, s1_h_r, s1_side_r;
  logic [cwo_pkg::VIEW_W-1:0] s1_view_r;
  logic [RNW-1:0] s1_ry_r, s1_rx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w_r    <= in_w;
      s1_h_r    <= in_h;
      s1_view_r <= in_view;
      s1_ry_r   <= in_ry;
      s1_rx_r   <= in_rx;
      s1_side_r <= side_prod[CB+15:16];
    end
  end

  // Stage 2: spans, divisors, grid orientation and full-view numerator.
  logic [SW-1:0] a0, d0, a1, d1;
  logic          swap;
  logic [cwo_pkg::OSIZE_W-1:0] osize;

  assign a0    = (cfg_across_r == '0) ? SW'(1) : cfg_across_r;
  assign d0    = (cfg_down_r == '0) ? SW'(1) : cfg_down_r;
  assign swap  = ((a0 < d0) && (s1_w_r > s1_h_r)) || ((a0 > d0) && (s1_w_r < s1_h_r));
  assign a1    = swap ? d0 : a0;
  assign d1    = swap ? a0 : d0;
  assign osize = (cfg_osize_r == '0) ? cwo_pkg::OSIZE_W'(1) : cfg_osize_r;

  logic [CB-1:0] s2_w_r, s2_h_r, s2_side_r, s2_hx_r, s2_hy_r, s2_sw_r, s2_sh_r;
  logic [cwo_pkg::VIEW_W-1:0] s2_view_r;
  logic [SW-1:0] s2_a_r, s2_d_r;
  logic [RNW-1:0] s2_ry_r, s2_rx_r;
  logic [CB:0]   s2_dy_r, s2_dx_r;
  logic [FNW-1:0] s2_fvn_r;
  logic [cwo_pkg::OSIZE_W:0] s2_fvd_r;
  logic [CB-1:0] sw_c, sh_c;

  assign sw_c = s1_w_r - s1_side_r;
  assign sh_c = s1_h_r - s1_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_w_r    <= s1_w_r;
      s2_h_r    <= s1_h_r;
      s2_side_r <= s1_side_r;
      s2_view_r <= s1_view_r;
      s2_sw_r   <= sw_c;
      s2_sh_r   <= sh_c;
      s2_hx_r   <= sw_c >> 1;
      s2_hy_r   <= sh_c >> 1;
      s2_a_r    <= a1;
      s2_d_r    <= d1;
      s2_ry_r   <= s1_ry_r;
      s2_rx_r   <= s1_rx_r;
      s2_dy_r   <= (CB+1)'(sh_c) + (CB+1)'(1);
      s2_dx_r   <= (CB+1)'(sw_c) + (CB+1)'(1);
      s2_fvn_r  <= (FNW)'(s1_side_r) * (FNW)'(cwo_pkg::FV_EDGE2) + (FNW)'(osize);
      s2_fvd_r  <= {osize, 1'b0};
    end
  end

  // Context that travels alongside the dividers.
  logic [CW-1:0] ctx2, ctx16, ctxl;
  assign ctx2 = {s2_a_r, s2_d_r, s2_sh_r, s2_sw_r, s2_hy_r, s2_hx_r, s2_side_r, s2_view_r,
                 s2_h_r, s2_w_r};

  cwo_dly #(.W(CW), .DEPTH(16)) u_ctx16 (.clk(clk), .en(en), .d(ctx2), .q(ctx16));
  cwo_dly #(.W(CW), .DEPTH(L-16)) u_ctxl (.clk(clk), .en(en), .d(ctx16), .q(ctxl));

  // Random mode: remainders of the random words.
  logic [RNW-1:0] rq_y, rq_x;
  logic [CB:0]    rr_y, rr_x, rr_yl, rr_xl;

  cwo_div #(.NW(RNW), .DW(CB+1)) u_rdiv_y (
    .clk(clk), .en(en), .num(s2_ry_r), .den(s2_dy_r), .quo(rq_y), .rem(rr_y)
  );
  cwo_div #(.NW(RNW), .DW(CB+1)) u_rdiv_x (
    .clk(clk), .en(en), .num(s2_rx_r), .den(s2_dx_r), .quo(rq_x), .rem(rr_x)
  );
  cwo_dly #(.W(2*CB+2), .DEPTH(L-RNW)) u_rpad (
    .clk(clk), .en(en), .d({rr_y, rr_x}), .q({rr_yl, rr_xl})
  );

  // Full view: edge limit.
  logic [FNW-1:0] fq, fql;
  logic [cwo_pkg::OSIZE_W:0] fr;

  cwo_div #(.NW(FNW), .DW(cwo_pkg::OSIZE_W+1)) u_fdiv (
    .clk(clk), .en(en), .num(s2_fvn_r), .den(s2_fvd_r), .quo(fq), .rem(fr)
  );
  cwo_dly #(.W(FNW), .DEPTH(L-FNW)) u_fpad (.clk(clk), .en(en), .d(fq), .q(fql));

  // Multi-crop: column and row of the view, then the grid offsets.
  logic [cwo_pkg::VIEW_W-1:0] qa, qb;
  logic [SW-1:0] col8, col16, row16, d8;

  cwo_div #(.NW(cwo_pkg::VIEW_W), .DW(SW)) u_gdiv_a (
    .clk(clk), .en(en), .num(s2_view_r), .den(s2_a_r), .quo(qa), .rem(col8)
  );
  cwo_dly #(.W(SW), .DEPTH(cwo_pkg::VIEW_W)) u_dpad (.clk(clk), .en(en), .d(s2_d_r), .q(d8));
  cwo_div #(.NW(cwo_pkg::VIEW_W), .DW(SW)) u_gdiv_b (
    .clk(clk), .en(en), .num(qa), .den(d8), .quo(qb), .rem(row16)
  );
  cwo_dly #(.W(SW), .DEPTH(cwo_pkg::VIEW_W)) u_cpad (.clk(clk), .en(en), .d(col8), .q(col16));

  logic [CB-1:0] c16_w, c16_h, c16_side, c16_hx, c16_hy, c16_sw, c16_sh;
  logic [cwo_pkg::VIEW_W-1:0] c16_view;
  logic [SW-1:0] c16_a, c16_d;
  assign {c16_a, c16_d, c16_sh, c16_sw, c16_hy, c16_hx, c16_side, c16_view, c16_h, c16_w} = ctx16;

  logic [GNW-1:0] gx_prod, gy_prod, gx_num, gy_num, gx_q, gy_q, gx_ql, gy_ql;
  logic [SW:0]    gx_den, gy_den, gx_r, gy_r;

  assign gx_prod = GNW'(c16_sw) * GNW'(col16);
  assign gy_prod = GNW'(c16_sh) * GNW'(row16);
  assign gx_num  = (c16_a > SW'(1)) ? (gx_prod << 1) + GNW'(c16_a - SW'(1)) : GNW'(c16_hx);
  assign gy_num  = (c16_d > SW'(1)) ? (gy_prod << 1) + GNW'(c16_d - SW'(1)) : GNW'(c16_hy);
  assign gx_den  = (c16_a > SW'(1)) ? {c16_a - SW'(1), 1'b0} : (SW+1)'(1);
  assign gy_den  = (c16_d > SW'(1)) ? {c16_d - SW'(1), 1'b0} : (SW+1)'(1);

  cwo_div #(.NW(GNW), .DW(SW+1)) u_gdiv_x (
    .clk(clk), .en(en), .num(gx_num), .den(gx_den), .quo(gx_q), .rem(gx_r)
  );
  cwo_div #(.NW(GNW), .DW(SW+1)) u_gdiv_y (
    .clk(clk), .en(en), .num(gy_num), .den(gy_den), .quo(gy_q), .rem(gy_r)
  );
  cwo_dly #(.W(2*GNW), .DEPTH(L-16-GNW)) u_gpad (
    .clk(clk), .en(en), .d({gx_q, gy_q}), .q({gx_ql, gy_ql})
  );

  // Final selection.
  logic [CB-1:0] cl_w, cl_h, cl_side, cl_hx, cl_hy, cl_sw, cl_sh;
  logic [cwo_pkg::VIEW_W-1:0] cl_view;
  logic [SW-1:0] cl_a, cl_d;
  assign {cl_a, cl_d, cl_sh, cl_sw, cl_hy, cl_hx, cl_side, cl_view, cl_h, cl_w} = ctxl;

  logic [1:0]    kx, ky;
  logic [CB:0]   fix_x, fix_y, res_x, res_y, res_side;
  logic          w_over, h_over;
  logic [FNW-1:0] w_ext, h_ext;
  cwo_pkg::err_t err;

  assign kx     = cwo_pkg::view_x(cl_view[4:0]);
  assign ky     = cwo_pkg::view_y(cl_view[4:0]);
  assign fix_x  = (kx == 2'd2) ? {cl_hx, 1'b0} : ((kx == 2'd1) ? (CB+1)'(cl_hx) : '0);
  assign fix_y  = (ky == 2'd2) ? {cl_hy, 1'b0} : ((ky == 2'd1) ? (CB+1)'(cl_hy) : '0);
  assign w_ext  = FNW'(cl_w);
  assign h_ext  = FNW'(cl_h);
  assign w_over = w_ext > fql;
  assign h_over = h_ext > fql;

  always_comb begin
    res_x = '0;
    res_y = '0;
    err   = cwo_pkg::ERR_OK;
    unique case (cfg_mode_r)
      cwo_pkg::MODE_RANDOM: begin
        res_x = rr_xl;
        res_y = rr_yl;
      end
      cwo_pkg::MODE_TEN: begin
        if (cl_view >= cwo_pkg::VIEW_W'(cwo_pkg::TEN_VIEWS)) err = cwo_pkg::ERR_VIEW;
        else begin
          res_x = fix_x;
          res_y = fix_y;
        end
      end
      cwo_pkg::MODE_CENTER: begin
        res_x = (CB+1)'(cl_hx);
        res_y = (CB+1)'(cl_hy);
      end
      cwo_pkg::MODE_EIGHTEEN: begin
        if (cl_view >= cwo_pkg::VIEW_W'(cwo_pkg::EIGHTEEN_VIEWS)) err = cwo_pkg::ERR_VIEW;
        else begin
          res_x = fix_x;
          res_y = fix_y;
        end
      end
      cwo_pkg::MODE_MULTI: begin
        res_x = gx_ql[CB:0];
        res_y = gy_ql[CB:0];
      end
      cwo_pkg::MODE_FULL: begin
        priority if (w_over && h_over) err = cwo_pkg::ERR_BIG;
        else if (w_over) res_x = (CB+1)'((w_ext - fql) >> 1);
        else if (h_over) res_y = (CB+1)'((h_ext - fql) >> 1);
      end
      default: err = cwo_pkg::ERR_MODE;
    endcase
    res_side = (CB+1)'(cl_side);
    if (err != cwo_pkg::ERR_OK) begin
      res_x    = '0;
      res_y    = '0;
      res_side = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {7'd0, err, OW'(res_side), OW'(res_y), OW'(res_x)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // A flagged result carries no window.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[40:39] != cwo_pkg::ERR_OK) |->
    (out_tdata[38:0] == '0))
    else $error("errored result carries a nonzero window");

  // The too-large error can only come from full-view mode.
  a_big_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[40:39] == cwo_pkg::ERR_BIG) |->
    (cfg_mode_r == cwo_pkg::MODE_FULL))
    else $error("too-large error outside full-view mode");

  // A stalled pipeline keeps every in-flight item where it is.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for crop_window_offset_calc_core.
// Drives crop requests with random gaps and stalls, predicts every window in a scoreboard class.
// Depends on cwo_pkg and the design files.
`timescale 1ns / 1ps

module tb;
  import cwo_pkg::*;

  localparam int IN_W = 96;
  localparam int LIMIT = 200000;
  localparam int LATENCY = 45;
  localparam int PHASE_ITEMS = 100;
  localparam int TOTAL_ITEMS = 1400;
  localparam int HOLD_AT_ITEM = 1005;
  localparam logic [MODE_W-1:0] MODE_UNDEF_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNDEF_B = 3'd7;
  localparam logic [1:0] XM [18] = '{0, 2, 0, 2, 1, 1, 2, 1, 0, 1, 0, 2, 0, 2, 1, 2, 1, 0};
  localparam logic [1:0] YM [18] = '{0, 0, 2, 2, 1, 0, 1, 2, 1, 1, 0, 0, 2, 2, 0, 1, 2, 1};

  class crop_scoreboard;
    logic [RATIO_W-1:0] ratio = 17'h10000;
    logic [MODE_W-1:0] mode = MODE_RANDOM;
    logic [SEG_W-1:0] across = 1;
    logic [SEG_W-1:0] down = 1;
    logic [OSIZE_W-1:0] osize = 224;
    logic [OUT_TDATA_W-1:0] windows[$];
    int errors = 0;

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_RATIO: ratio = v;
        REG_MODE: mode = v[MODE_W-1:0];
        REG_ACROSS: across = v[SEG_W-1:0];
        REG_DOWN: down = v[SEG_W-1:0];
        REG_OSIZE: osize = v[OSIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned grid_pos(longint unsigned span, longint unsigned half,
                                       longint unsigned segs, longint unsigned idx);
      if (segs <= 1) return half;
      return (2 * span * idx + segs - 1) / (2 * (segs - 1));
    endfunction

    function void note_request(logic [IN_W-1:0] d);
      longint unsigned w, h, v, ry, rx, r, mn, side, hx, hy, x, y, a, dn, t, i, os, m;
      err_t err;
      w = d[12:0]; h = d[25:13]; v = d[33:26]; ry = d[64:34]; rx = d[95:65];
      r = (ratio > 17'h10000) ? 65536 : ratio;
      mn = (w < h) ? w : h;
      side = (mn * r) >> 16;
      hx = (w - side) >> 1;
      hy = (h - side) >> 1;
      x = 0; y = 0; err = ERR_OK;
      case (mode)
        MODE_RANDOM: begin
          y = ry % (h - side + 1);
          x = rx % (w - side + 1);
        end
        MODE_TEN: begin
          if (v >= TEN_VIEWS) err = ERR_VIEW;
          else begin x = hx * XM[v]; y = hy * YM[v]; end
        end
        MODE_CENTER: begin x = hx; y = hy; end
        MODE_EIGHTEEN: begin
          if (v >= EIGHTEEN_VIEWS) err = ERR_VIEW;
          else begin x = hx * XM[v]; y = hy * YM[v]; end
        end
        MODE_MULTI: begin
          a = (across == 0) ? 1 : across;
          dn = (down == 0) ? 1 : down;
          if ((a < dn && w > h) || (a > dn && w < h)) begin t = a; a = dn; dn = t; end
          i = v % (a * dn);
          x = grid_pos(w - side, hx, a, i % a);
          y = grid_pos(h - side, hy, dn, i / a);
        end
        MODE_FULL: begin
          os = (osize == 0) ? 1 : osize;
          m = (2 * side * 1400 + os) / (2 * os);
          if (w > m && h > m) err = ERR_BIG;
          else if (w > m) x = (w - m) >> 1;
          else if (h > m) y = (h - m) >> 1;
        end
        default: err = ERR_MODE;
      endcase
      if (err != ERR_OK) begin x = 0; y = 0; side = 0; end
      windows.push_back({7'd0, err, side[12:0], y[12:0], x[12:0]});
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] got);
      logic [OUT_TDATA_W-1:0] exp;
      if (windows.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
        return;
      end
      exp = windows.pop_front();
      if (got[12:0] !== exp[12:0])
        $display("%0t: x_offset exp %0d act %0d", $time, exp[12:0], got[12:0]);
      if (got[25:13] !== exp[25:13])
        $display("%0t: y_offset exp %0d act %0d", $time, exp[25:13], got[25:13]);
      if (got[38:26] !== exp[38:26])
        $display("%0t: crop_side exp %0d act %0d", $time, exp[38:26], got[38:26]);
      if (got[40:39] !== exp[40:39])
        $display("%0t: error_code exp %0d act %0d", $time, exp[40:39], got[40:39]);
      if (got[47:41] !== exp[47:41])
        $display("%0t: pad bits exp %h act %h", $time, exp[47:41], got[47:41]);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  crop_scoreboard sb = new();
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int sent = 0;

  crop_window_offset_calc_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function bit idle_roll();
    if (cycle_cnt > 800 && cycle_cnt < 1600) return 0;
    return $urandom_range(0, 99) < 8;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);

  // The long hold starts in the middle of a phase so that the sender keeps offering beats.
  always @(negedge clk) begin
    if (!hold_done && sent >= HOLD_AT_ITEM) begin
      hold_done = 1;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 0;
    end else begin
      out_tready <= !idle_roll();
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic send(logic [IN_W-1:0] d);
    @(negedge clk);
    while (idle_roll()) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(d);
    sent++;
  endtask

  function automatic logic [12:0] rand_edge();
    case ($urandom_range(0, 9))
      0: return 13'($urandom_range(0, 16));
      1: return 13'h1FFF;
      default: return 13'($urandom_range(1, 8191));
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rand_item(logic [MODE_W-1:0] mode);
    logic [7:0] v;
    logic [30:0] ry, rx;
    ry = $urandom();
    rx = $urandom();
    if ((mode == MODE_TEN || mode == MODE_EIGHTEEN) && $urandom_range(0, 3) != 0)
      v = $urandom_range(0, 19);
    else
      v = $urandom_range(0, 255);
    return {rx, ry, v, rand_edge(), rand_edge()};
  endfunction

  function automatic logic [IN_W-1:0] corner_item(int k);
    case (k % 6)
      0: return {31'h7FFFFFFF, 31'h7FFFFFFF, 8'd255, 13'h1FFF, 13'h1FFF};
      1: return {31'd0, 31'd0, 8'd0, 13'd5, 13'd0};
      2: return {31'd12345, 31'd999, 8'd17, 13'h1FFF, 13'd1};
      3: return {31'd7, 31'h40000000, 8'd9, 13'd1, 13'h1FFF};
      4: return {31'h2AAAAAAA, 31'h55555555, 8'd18, 13'd3, 13'd7};
      default: return {31'd1, 31'd1, 8'd10, 13'd640, 13'd480};
    endcase
  endfunction

  task automatic run_phase(logic [16:0] ratio, logic [MODE_W-1:0] mode, logic [4:0] a,
                           logic [4:0] d, logic [11:0] os, int corners, bit set_cfg);
    if (set_cfg) begin
      write_reg(REG_RATIO, ratio);
      write_reg(REG_MODE, 17'(mode));
      write_reg(REG_ACROSS, 17'(a));
      write_reg(REG_DOWN, 17'(d));
      write_reg(REG_OSIZE, 17'(os));
    end
    for (int k = 0; k < PHASE_ITEMS; k++)
      send(k < corners ? corner_item(k + 2 * mode) : rand_item(mode));
    @(negedge clk);
    in_tvalid <= 0;
    while (sb.windows.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    run_phase(17'h10000, MODE_RANDOM, 1, 1, 224, 2, 0);
    run_phase(17'd0, MODE_TEN, 1, 1, 224, 2, 1);
    run_phase(17'h1FFFF, MODE_CENTER, 2, 2, 100, 2, 1);
    run_phase(17'd32768, MODE_EIGHTEEN, 1, 1, 224, 2, 1);
    run_phase(17'd49152, MODE_MULTI, 3, 5, 224, 2, 1);
    run_phase(17'd1, MODE_MULTI, 0, 31, 224, 2, 1);
    run_phase(17'd40000, MODE_FULL, 1, 1, 0, 2, 1);
    run_phase(17'h10000, MODE_FULL, 16, 16, 4095, 2, 1);
    run_phase(17'd1000, MODE_FULL, 1, 1, 1, 2, 1);
    run_phase(17'd30000, MODE_UNDEF_A, 1, 1, 224, 1, 1);
    run_phase(17'd30000, MODE_UNDEF_B, 1, 1, 224, 1, 1);
    while (sent < TOTAL_ITEMS)
      run_phase($urandom_range(0, 131071), $urandom_range(0, 5), $urandom_range(0, 31),
                $urandom_range(0, 31), $urandom_range(0, 4095), 0, 1);
    if (sb.errors == 0 && sb.windows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== crop_window_offset_calc_core.f =====
design/cwo_pkg.sv
design/cwo_div.sv
design/cwo_dly.sv
design/crop_window_offset_calc_core.sv
verif/tb.sv
